/* hdl/indexed_min_heap_queue_defines.svh */
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_defines.svh
// Assertion macros used by the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define IMHQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define IMHQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/imhq_pkg.sv */
// ----------------------------------------------------------------------------
// imhq_pkg
// Item types and operation / status codes of the indexed min-heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imhq_pkg;

  // Operation codes
  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_POP      = 2'd1;
  localparam logic [1:0] MODE_DECREASE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ABSENT    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  node_index;
    logic [23:0] new_key;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  popped_index;
    logic [23:0] popped_key;
    logic        queue_empty;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } out_item_t;

endpackage

/* hdl/imhq_if.sv */
// ----------------------------------------------------------------------------
// imhq_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imhq_in_if import imhq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imhq_out_if import imhq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/indexed_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: one item at a time, the heap walked one level at a time.
// Errors, an empty pop and an unused mode go straight to the result; insert and
// decrease sift the entry up level by level until a compare stops it or it
// reaches the root; pop takes the root and sifts the last entry down until a
// compare stops it or it has no child. Each result waits for out ready.
// Reset empties the queue at once; heap, slot and key memories keep contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_min_heap_queue import imhq_pkg::*; #(
  parameter int NODES    = 64,
  parameter int KEY_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  imhq_in_if.sink          in_i,
  imhq_out_if.source       out_o
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;  // node index width
  localparam int CW = $clog2(NODES + 1);                // heap slot / count width

  typedef logic [IW-1:0]       idx_t;
  typedef logic [CW-1:0]       slot_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_POS, S_UP_RD, S_UP_KEY, S_UP_CMP,
    S_POP_RD, S_POP_KEY, S_DN_RD, S_DN_IDX, S_DN_CMP, S_OUT
  } state_e;

  // Memories
  idx_t  heap_mem [0:NODES];
  slot_t slot_mem [0:NODES-1];
  key_t  key_mem  [0:NODES-1];

  state_e          state_q;
  logic [NODES-1:0] present_q;
  slot_t           size_q;
  slot_t           pos_q;
  slot_t           limit_q;
  idx_t            cur_idx_q;
  key_t            cur_key_q;
  idx_t            top_idx_q;
  out_item_t       out_q;

  idx_t  heap_rd_a_q, heap_rd_b_q;
  slot_t slot_rd_q;
  key_t  key_rd_a_q, key_rd_b_q;

  // Memory port controls
  logic  heap_re;
  slot_t heap_ra, heap_rb;
  logic  heap_we;
  slot_t heap_wa;
  idx_t  heap_wd;
  logic  slot_we;
  idx_t  slot_wa;
  slot_t slot_wd;
  logic  key_we;

  // Decoded input item
  idx_t  in_idx;
  key_t  in_key;
  logic  in_range;
  logic  accept;

  // Outcome of an accepted item
  out_item_t take_out;
  state_e    take_state;
  logic      take_ins;

  // Sift-down child choice
  logic [CW:0] two_p;
  logic        use_r;
  slot_t       child;
  idx_t        child_idx;
  key_t        child_key;

  assign in_idx   = IW'(in_i.data.node_index);
  assign in_key   = KEY_BITS'(in_i.data.new_key);
  assign in_range = (32'(in_i.data.node_index) < NODES);
  assign accept   = in_i.valid && in_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = out_q;

  assign two_p     = {pos_q, 1'b0};
  assign use_r     = (two_p < {1'b0, limit_q}) && (key_rd_a_q > key_rd_b_q);
  assign child     = use_r ? CW'(two_p + 1'b1) : CW'(two_p);
  assign child_idx = use_r ? heap_rd_b_q : heap_rd_a_q;
  assign child_key = use_r ? key_rd_b_q : key_rd_a_q;

  // Result fields and first step for the item at the input
  always_comb begin
    take_out             = '0;
    take_out.status      = ST_OK;
    take_out.entry_count = 7'(size_q);
    take_out.queue_empty = (size_q == '0);
    take_state           = S_OUT;
    take_ins             = 1'b0;
    if (in_i.data.mode == MODE_INSERT || in_i.data.mode == MODE_DECREASE) begin
      priority if (!in_range) begin
        take_out.status = ST_ABSENT;
      end else if (present_q[in_idx]) begin
        take_state = S_UP_POS;
      end else if (in_i.data.mode == MODE_DECREASE) begin
        take_out.status = ST_ABSENT;
      end else if (size_q == slot_t'(NODES)) begin
        take_out.status = ST_FULL;
      end else begin
        take_ins             = 1'b1;
        take_state           = S_UP_RD;
        take_out.entry_count = 7'(size_q + 1'b1);
        take_out.queue_empty = 1'b0;
      end
    end else if (in_i.data.mode == MODE_POP) begin
      if (size_q == '0) begin
        take_out.status = ST_POP_EMPTY;
      end else begin
        take_state = S_POP_RD;
      end
    end
  end

  // Heap-memory read addresses
  always_comb begin
    heap_re = 1'b0;
    heap_ra = slot_t'(1);
    heap_rb = size_q;
    unique case (state_q)
      S_IDLE: begin
        heap_re = accept && (in_i.data.mode == MODE_POP);
      end
      S_UP_RD: begin
        heap_re = 1'b1;
        heap_ra = pos_q >> 1;
      end
      S_DN_RD: begin
        heap_re = 1'b1;
        heap_ra = CW'(two_p);
        heap_rb = CW'(two_p + 1'b1);
      end
      default: heap_re = 1'b0;
    endcase
  end

  // Heap and slot writes: hole moves or final placement
  always_comb begin
    heap_we = 1'b0;
    heap_wa = pos_q;
    heap_wd = cur_idx_q;
    slot_we = 1'b0;
    slot_wa = cur_idx_q;
    slot_wd = pos_q;
    unique case (state_q)
      S_UP_RD: begin
        heap_we = (pos_q == slot_t'(1));
        slot_we = (pos_q == slot_t'(1));
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (key_rd_a_q > cur_key_q) begin
          heap_wd = heap_rd_a_q;
          slot_wa = heap_rd_a_q;
        end
      end
      S_DN_RD: begin
        heap_we = (two_p > {1'b0, limit_q});
        slot_we = (two_p > {1'b0, limit_q});
      end
      S_DN_CMP: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (cur_key_q > child_key) begin
          heap_wd = child_idx;
          slot_wa = child_idx;
        end
      end
      default: heap_we = 1'b0;
    endcase
  end

  assign key_we = accept && in_range
               && ((in_i.data.mode == MODE_DECREASE && present_q[in_idx])
                || (in_i.data.mode == MODE_INSERT
                    && (present_q[in_idx] || size_q != slot_t'(NODES))));

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) begin
      heap_rd_a_q <= heap_mem[heap_ra];
      heap_rd_b_q <= heap_mem[heap_rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take_ins) begin
      slot_mem[in_idx] <= CW'(size_q + 1'b1);
    end else if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[in_idx];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[in_idx] <= in_key;
    key_rd_a_q <= key_mem[heap_rd_a_q];
    key_rd_b_q <= key_mem[heap_rd_b_q];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      present_q <= '0;
      size_q    <= '0;
      pos_q     <= '0;
      limit_q   <= '0;
      cur_idx_q <= '0;
      cur_key_q <= '0;
      top_idx_q <= '0;
      out_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_q     <= take_out;
            cur_idx_q <= in_idx;
            cur_key_q <= in_key;
            state_q   <= take_state;
            if (take_ins) begin
              size_q            <= CW'(size_q + 1'b1);
              pos_q             <= CW'(size_q + 1'b1);
              present_q[in_idx] <= 1'b1;
            end
          end
        end
        S_UP_POS: begin
          pos_q   <= slot_rd_q;
          state_q <= S_UP_RD;
        end
        S_UP_RD: begin
          state_q <= (pos_q == slot_t'(1)) ? S_OUT : S_UP_KEY;
        end
        S_UP_KEY: begin
          state_q <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (key_rd_a_q > cur_key_q) begin
            pos_q   <= pos_q >> 1;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_POP_RD: begin
          top_idx_q <= heap_rd_a_q;
          cur_idx_q <= heap_rd_b_q;
          state_q   <= S_POP_KEY;
        end
        S_POP_KEY: begin
          out_q                <= {6'(top_idx_q), 24'(key_rd_a_q),
                                   (size_q == slot_t'(1)), 7'(size_q - 1'b1), ST_OK};
          present_q[top_idx_q] <= 1'b0;
          cur_key_q            <= key_rd_b_q;
          size_q               <= CW'(size_q - 1'b1);
          limit_q              <= CW'(size_q - 1'b1);
          pos_q                <= slot_t'(1);
          state_q              <= (size_q == slot_t'(1)) ? S_OUT : S_DN_RD;
        end
        S_DN_RD: begin
          state_q <= (two_p > {1'b0, limit_q}) ? S_OUT : S_DN_IDX;
        end
        S_DN_IDX: begin
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cur_key_q > child_key) begin
            pos_q   <= child;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/imhq_checker.sv */
// ----------------------------------------------------------------------------
// imhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_min_heap_queue_defines.svh"

module imhq_checker import imhq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // One item in flight: no new item while a result is pending
  `IMHQ_ASSERT_IMP(a_no_take_while_out, out_valid_i, !in_ready_i, "input taken during result")

  // Empty flag agrees with the count
  `IMHQ_ASSERT_IMP(a_empty_count, out_valid_i, out_data_i.queue_empty == (out_data_i.entry_count == 7'd0), "empty flag mismatch")

  // Pop on empty returns nothing and leaves the queue empty
  `IMHQ_ASSERT_IMP(a_pop_empty, out_valid_i && out_data_i.status == ST_POP_EMPTY, out_data_i.entry_count == 7'd0 && out_data_i.popped_index == 6'd0 && out_data_i.popped_key == 24'd0, "bad pop-on-empty result")

  // A stalled result holds
  `IMHQ_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
